@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

@@ rtl/ili_pkg.sv @@
`timescale 1ns / 1ps

package ili_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = IDX_W + 1;
  localparam int DEPTH    = 2 * CAPACITY;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_LIST
  } state_t;

  typedef enum logic [1:0] {
    MODE_INS,
    MODE_DEL,
    MODE_COPY
  } mode_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/ili_if.sv @@
`timescale 1ns / 1ps

interface ili_cmd_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [ili_pkg::POS_W-1:0]       position;
  logic signed [ili_pkg::VAL_W-1:0] new_value;

  modport source (output valid, action, position, new_value, input ready);
  modport sink (input valid, action, position, new_value, output ready);
endinterface

interface ili_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [ili_pkg::VAL_W-1:0] element_value;
  logic                            last_of_listing;
  logic                            list_empty;
  logic                            insert_dropped;

  modport source (output valid, element_value, last_of_listing, list_empty, insert_dropped,
                  input ready);
  modport sink (input valid, element_value, last_of_listing, list_empty, insert_dropped,
                output ready);
endinterface

@@ rtl/ili_store.sv @@
`timescale 1ns / 1ps

// Two banks of the list: one is read while the edited list is written to the other.
module ili_store (
  input  logic                        clk,
  input  ili_pkg::mem_req_t           req,
  output logic [ili_pkg::VAL_W-1:0]   rdata
);

  logic [ili_pkg::VAL_W-1:0] mem [ili_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ rtl/ili_seq.sv @@
`timescale 1ns / 1ps

module ili_seq (
  input  logic                      clk,
  input  logic                      rst,
  ili_cmd_if.sink                   cmd,
  ili_res_if.source                 res,
  output ili_pkg::mem_req_t         req,
  input  logic [ili_pkg::VAL_W-1:0] rdata
);

  localparam int CNT_W = ili_pkg::CNT_W;
  localparam int IDX_W = ili_pkg::IDX_W;

  ili_pkg::state_t           state, state_next;
  ili_pkg::mode_t            mode;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          n_new;
  logic [CNT_W-1:0]          p;
  logic [CNT_W-1:0]          k;
  logic [CNT_W-1:0]          k_adv;
  logic [CNT_W-1:0]          src;
  logic [ili_pkg::VAL_W-1:0] v;
  logic                      dropped;
  logic                      bank;
  logic                      sel_new;
  logic                      cmd_fire;
  logic                      res_fire;
  logic                      is_empty;
  logic                      is_last;
  logic [ili_pkg::VAL_W-1:0] out_value;
  logic [ili_pkg::POS_W-1:0] count_wide;

  assign cmd_fire   = cmd.valid && cmd.ready;
  assign res_fire   = res.valid && res.ready;
  assign is_empty   = (n_new == '0);
  assign is_last    = is_empty || ((k + CNT_W'(1)) == n_new);
  assign out_value  = is_empty ? '0 : (sel_new ? v : rdata);
  assign count_wide = ili_pkg::POS_W'(count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ili_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          state_next = ili_pkg::ST_PREP;
        end
      end
      ili_pkg::ST_PREP: begin
        state_next = ili_pkg::ST_LIST;
      end
      ili_pkg::ST_LIST: begin
        if (res_fire && is_last) begin
          state_next = ili_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ili_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    cmd.ready           = (state == ili_pkg::ST_IDLE);
    res.valid           = (state == ili_pkg::ST_LIST);
    res.element_value   = $signed(out_value);
    res.last_of_listing = is_last;
    res.list_empty      = is_empty;
    res.insert_dropped  = dropped;
  end

  // Source place in the old list for the next place of the listing.
  always_comb begin
    k_adv = k;
    if ((state == ili_pkg::ST_LIST) && res_fire && !is_last) begin
      k_adv = k + CNT_W'(1);
    end
    unique case (mode)
      ili_pkg::MODE_INS:  src = (k_adv < p) ? k_adv : k_adv - CNT_W'(1);
      ili_pkg::MODE_DEL:  src = (k_adv < p) ? k_adv : k_adv + CNT_W'(1);
      ili_pkg::MODE_COPY: src = k_adv;
      default:            src = k_adv;
    endcase
    req.raddr = {bank, src[IDX_W-1:0]};
    req.we    = res_fire && !is_empty;
    req.waddr = {~bank, k[IDX_W-1:0]};
    req.wdata = out_value;
  end

  always_ff @(posedge clk) begin
    sel_new <= (mode == ili_pkg::MODE_INS) && (k_adv == p);
    if (rst) begin
      state   <= ili_pkg::ST_IDLE;
      count   <= '0;
      bank    <= 1'b0;
      k       <= '0;
      mode    <= ili_pkg::MODE_COPY;
      n_new   <= '0;
      p       <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_fire) begin
        k       <= '0;
        v       <= cmd.new_value;
        dropped <= 1'b0;
        p       <= '0;
        if (cmd.action == ili_pkg::ACT_INSERT) begin
          if (count == CNT_W'(ili_pkg::CAPACITY)) begin
            mode    <= ili_pkg::MODE_COPY;
            dropped <= 1'b1;
            n_new   <= count;
          end else begin
            mode  <= ili_pkg::MODE_INS;
            n_new <= count + CNT_W'(1);
            p     <= (cmd.position > count_wide) ? count : cmd.position[CNT_W-1:0];
          end
        end else if (cmd.position < count_wide) begin
          mode  <= ili_pkg::MODE_DEL;
          n_new <= count - CNT_W'(1);
          p     <= cmd.position[CNT_W-1:0];
        end else begin
          mode  <= ili_pkg::MODE_COPY;
          n_new <= count;
        end
      end
      if ((state == ili_pkg::ST_LIST) && res_fire) begin
        k <= k_adv;
        if (is_last) begin
          count <= n_new;
          bank  <= ~bank;
        end
      end
    end
  end

endmodule

@@ rtl/indexed_list_insert_delete.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Carries
// cmd      in         action, position, new_value
// res      out        element_value, last_of_listing, list_empty, insert_dropped
//
// A command passes through a prepare state into a listing of N items, N being the list
// length afterwards (1 for an empty list).
// While res is ready, the listing streams one item a cycle from the single read port
// of the list store, while the edited list is written into the other bank.
// Reset is synchronous and empties the list; the store itself is not cleared.
// A stall on res holds the listing in place; cmd is ready only between commands.
module indexed_list_insert_delete (
  input  logic      clk,
  input  logic      rst,
  ili_cmd_if.sink   cmd,
  ili_res_if.source res
);

  ili_pkg::mem_req_t         req;
  logic [ili_pkg::VAL_W-1:0] rdata;

  ili_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .res   (res),
    .req   (req),
    .rdata (rdata)
  );

  ili_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

@@ rtl/ili_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ili_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [ili_pkg::VAL_W-1:0]   res_value,
  input logic                        res_last,
  input logic                        res_empty,
  input logic                        res_dropped
);

  logic [ili_pkg::VAL_W+2:0] res_payload;

  assign res_payload = {res_value, res_last, res_empty, res_dropped};

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_payload))
  `ASSERT_SAME(a_busy_excl, clk, rst, cmd_ready, !res_valid)
  `ASSERT_SAME(a_empty_last, clk, rst, res_valid && res_empty, res_last && (res_value == '0))
  `ASSERT_NEXT(a_done_ready, clk, rst, res_valid && res_ready && res_last, cmd_ready && !res_valid)

endmodule

bind indexed_list_insert_delete ili_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_value   (res.element_value),
  .res_last    (res.last_of_listing),
  .res_empty   (res.list_empty),
  .res_dropped (res.insert_dropped)
);

@@ tb/indexed_list_insert_delete_tb.sv @@
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;

  typedef struct {
    logic                             action;
    logic [ili_pkg::POS_W-1:0]        position;
    logic signed [ili_pkg::VAL_W-1:0] new_value;
  } list_cmd_t;

  typedef struct {
    logic signed [ili_pkg::VAL_W-1:0] element_value;
    logic                             last_of_listing;
    logic                             list_empty;
    logic                             insert_dropped;
  } listing_item_t;

  localparam int NUM_CMDS    = 350;
  localparam int HOLD_CYCLES = 250;

  logic clk;
  logic rst;

  ili_cmd_if cmd_ch();
  ili_res_if res_ch();

  indexed_list_insert_delete uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  list_cmd_t                 pending_cmds[$];
  list_cmd_t                 offered;
  listing_item_t             listing_expected[$];
  logic [ili_pkg::VAL_W-1:0] shadow_list[ili_pkg::CAPACITY];
  int unsigned               shadow_len = 0;
  int unsigned               gen_len = 0;
  int unsigned               accepted_cmds = 0;
  int unsigned               items_checked = 0;
  int unsigned               refused_inserts = 0;
  int unsigned               peak_len = 0;
  int unsigned               error_count = 0;
  logic                      hold_off;
  logic                      calm;

  // Neither side idles while this window of commands is in flight.
  assign calm = (accepted_cmds >= 200) && (accepted_cmds < 260);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [ili_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned insert_position();
    case ($urandom_range(9))
      0: return 0;
      1: return gen_len;
      2, 3: return $urandom_range(255);
      default: return $urandom_range(gen_len);
    endcase
  endfunction

  function automatic int unsigned delete_position();
    if (gen_len == 0 || $urandom_range(9) == 0) begin
      return $urandom_range(255);
    end
    return $urandom_range(gen_len - 1);
  endfunction

  // The generator keeps its own count of the length so that it can steer the list.
  function automatic void queue_cmd(logic action, int unsigned position,
                                    logic signed [ili_pkg::VAL_W-1:0] value);
    list_cmd_t c;
    c.action    = action;
    c.position  = position[ili_pkg::POS_W-1:0];
    c.new_value = value;
    pending_cmds.push_back(c);
    if (action == ili_pkg::ACT_INSERT) begin
      if (gen_len < ili_pkg::CAPACITY) begin
        gen_len++;
      end
    end else if (position < gen_len) begin
      gen_len--;
    end
  endfunction

  function automatic void apply_list_command(list_cmd_t c);
    logic          dropped;
    int unsigned   slot;
    int unsigned   k;
    listing_item_t r;
    dropped = 1'b0;
    if (c.action == ili_pkg::ACT_INSERT) begin
      if (shadow_len >= ili_pkg::CAPACITY) begin
        dropped = 1'b1;
        refused_inserts++;
      end else begin
        slot = (c.position > shadow_len) ? shadow_len : c.position;
        for (k = shadow_len; k > slot; k--) begin
          shadow_list[k] = shadow_list[k - 1];
        end
        shadow_list[slot] = c.new_value;
        shadow_len++;
      end
    end else if (c.position < shadow_len) begin
      for (k = c.position; k + 1 < shadow_len; k++) begin
        shadow_list[k] = shadow_list[k + 1];
      end
      shadow_len--;
    end
    if (shadow_len > peak_len) begin
      peak_len = shadow_len;
    end
    if (shadow_len == 0) begin
      r.element_value   = '0;
      r.last_of_listing = 1'b1;
      r.list_empty      = 1'b1;
      r.insert_dropped  = dropped;
      listing_expected.push_back(r);
    end else begin
      for (k = 0; k < shadow_len; k++) begin
        r.element_value   = shadow_list[k];
        r.last_of_listing = (k + 1 == shadow_len);
        r.list_empty      = 1'b0;
        r.insert_dropped  = dropped;
        listing_expected.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      fire = cmd_ch.valid && cmd_ch.ready;
      if (fire) begin
        apply_list_command(offered);
        accepted_cmds <= accepted_cmds + 1;
      end
      if (!cmd_ch.valid || fire) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          offered = pending_cmds.pop_front();
          cmd_ch.valid     <= 1'b1;
          cmd_ch.action    <= offered.action;
          cmd_ch.position  <= offered.position;
          cmd_ch.new_value <= offered.new_value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    listing_item_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        items_checked++;
        if (listing_expected.size() == 0) begin
          $error("unexpected listing item: element_value %0d", res_ch.element_value);
          error_count++;
        end else begin
          want = listing_expected.pop_front();
          if (res_ch.element_value !== want.element_value) begin
            $error("element_value: expected %0d, got %0d",
                   want.element_value, res_ch.element_value);
            error_count++;
          end
          if (res_ch.last_of_listing !== want.last_of_listing) begin
            $error("last_of_listing: expected %0b, got %0b",
                   want.last_of_listing, res_ch.last_of_listing);
            error_count++;
          end
          if (res_ch.list_empty !== want.list_empty) begin
            $error("list_empty: expected %0b, got %0b", want.list_empty, res_ch.list_empty);
            error_count++;
          end
          if (res_ch.insert_dropped !== want.insert_dropped) begin
            $error("insert_dropped: expected %0b, got %0b",
                   want.insert_dropped, res_ch.insert_dropped);
            error_count++;
          end
        end
      end
      res_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 38);
    end
  end

  // The receiver stops for a long stretch so that a listing backs up and the
  // command channel stalls.
  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    while (accepted_cmds < 70) begin
      @(posedge clk);
    end
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("indexed_list_insert_delete_tb: errors");
    $finish;
  end

  initial begin
    int unsigned seg;
    int unsigned mode;
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ili_pkg::ACT_INSERT;
    cmd_ch.position  = '0;
    cmd_ch.new_value = '0;
    res_ch.ready     = 1'b0;

    queue_cmd(ili_pkg::ACT_DELETE, 0, '0);
    queue_cmd(ili_pkg::ACT_INSERT, 0, 32'sh7FFFFFFF);
    queue_cmd(ili_pkg::ACT_INSERT, 255, 32'sh80000000);
    queue_cmd(ili_pkg::ACT_INSERT, 0, '1);
    queue_cmd(ili_pkg::ACT_INSERT, 1, '0);
    queue_cmd(ili_pkg::ACT_INSERT, 2, 32'sh5A5AA5A5);
    queue_cmd(ili_pkg::ACT_DELETE, 255, '1);
    queue_cmd(ili_pkg::ACT_DELETE, gen_len - 1, '0);
    queue_cmd(ili_pkg::ACT_DELETE, 0, '0);
    queue_cmd(ili_pkg::ACT_DELETE, gen_len, '0);
    queue_cmd(ili_pkg::ACT_DELETE, 1, '0);
    queue_cmd(ili_pkg::ACT_DELETE, 0, '0);
    queue_cmd(ili_pkg::ACT_DELETE, 0, '0);
    queue_cmd(ili_pkg::ACT_DELETE, 0, 32'sh80000000);

    // The first random segment always fills the list and then overfills it.
    seg = 0;
    while (pending_cmds.size() < NUM_CMDS) begin
      mode = (seg == 0) ? 0 : $urandom_range(9);
      seg++;
      if (mode == 0) begin
        while (gen_len < ili_pkg::CAPACITY) begin
          queue_cmd(ili_pkg::ACT_INSERT, insert_position(), pick_value());
        end
        repeat ($urandom_range(3, 1)) begin
          queue_cmd(ili_pkg::ACT_INSERT, insert_position(), pick_value());
        end
      end else if (mode == 1) begin
        while (gen_len > 0) begin
          queue_cmd(ili_pkg::ACT_DELETE, delete_position(), pick_value());
        end
        queue_cmd(ili_pkg::ACT_DELETE, $urandom_range(255), pick_value());
      end else begin
        repeat (12) begin
          if ($urandom_range(ili_pkg::CAPACITY) >= gen_len) begin
            queue_cmd(ili_pkg::ACT_INSERT, insert_position(), pick_value());
          end else begin
            queue_cmd(ili_pkg::ACT_DELETE, delete_position(), pick_value());
          end
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_ch.valid || listing_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("Applied %0d commands and checked %0d listing items.",
             accepted_cmds, items_checked);
    $display("Inserts refused on a full list: %0d; longest list: %0d of %0d.",
             refused_inserts, peak_len, ili_pkg::CAPACITY);
    if (error_count == 0) begin
      $display("indexed_list_insert_delete_tb: clean");
    end else begin
      $display("indexed_list_insert_delete_tb: errors");
    end
    $finish;
  end

endmodule

@@ indexed_list_insert_delete.f @@
+incdir+rtl
rtl/ili_pkg.sv
rtl/ili_if.sv
rtl/ili_store.sv
rtl/ili_seq.sv
rtl/indexed_list_insert_delete.sv
rtl/ili_checker.sv
tb/indexed_list_insert_delete_tb.sv
